[rtl/sabv_pkg.sv]
// ----------------------------------------------------------------------------
// Signed angle between vectors: shared package
// Widths, payload structs, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package sabv_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CORDIC_STAGES  = 16;
    localparam int TABLE_LEN      = 24;
    localparam int NUM_ITER       = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int PROD_W = 2 * COMPONENT_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int XY_W   = PROD_W + 4;
    localparam int Z_W    = 34;
    localparam int ANG_W  = 16;
    localparam int MAG_W  = 15;
    localparam int IDX_W  = $clog2(TABLE_LEN);
    localparam int RND_W  = Z_W - 17;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(64'sd1686629713);
    localparam logic [MAG_W-1:0]      PI_Q13      = MAG_W'(25736);
    localparam logic [MAG_W-1:0]      HALF_PI_Q13 = MAG_W'(12868);

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] a_x;
        logic signed [COMPONENT_BITS-1:0] a_y;
        logic signed [COMPONENT_BITS-1:0] b_x;
        logic signed [COMPONENT_BITS-1:0] b_y;
    } t_in;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle;
        logic                    zero_vector;
    } t_out;

    // Per-item control that rides alongside the CORDIC datapath.
    typedef struct packed {
        logic             zero_vec;
        logic             fixed;
        logic [MAG_W-1:0] fixed_mag;
        logic             pos;
    } t_side;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        t_side                  side;
    } t_cor;

    // atan(2^-i) in Q2.30, truncated.
    function automatic logic [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return Z_W'(v);
    endfunction

endpackage

[rtl/sabv_products.sv]
// ----------------------------------------------------------------------------
// Signed angle between vectors: products
// Two register stages: the four component products, then dot and cross sums.
// ----------------------------------------------------------------------------
module sabv_products (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  sabv_pkg::t_in                         i_data,
    output logic                                  o_valid,
    output logic signed [sabv_pkg::SUM_W-1:0]     o_dot,
    output logic signed [sabv_pkg::SUM_W-1:0]     o_cross,
    output logic                                  o_zero
);

    logic signed [sabv_pkg::PROD_W-1:0] n_p_xx, n_p_yy, n_p_xy, n_p_yx;
    logic signed [sabv_pkg::PROD_W-1:0] r_p_xx, r_p_yy, r_p_xy, r_p_yx;
    logic                               n_zero, r_zero_a;
    logic                               r_valid_a;
    logic signed [sabv_pkg::SUM_W-1:0]  n_dot, n_cross;
    logic signed [sabv_pkg::SUM_W-1:0]  r_dot, r_cross;
    logic                               r_zero_b, r_valid_b;

    always_comb begin
        n_p_xx = i_data.a_x * i_data.b_x;
        n_p_yy = i_data.a_y * i_data.b_y;
        n_p_xy = i_data.a_x * i_data.b_y;
        n_p_yx = i_data.a_y * i_data.b_x;
        n_zero = ((i_data.a_x == '0) && (i_data.a_y == '0)) ||
                 ((i_data.b_x == '0) && (i_data.b_y == '0));
    end

    always_comb begin
        n_dot   = sabv_pkg::SUM_W'(r_p_xx) + sabv_pkg::SUM_W'(r_p_yy);
        n_cross = sabv_pkg::SUM_W'(r_p_xy) - sabv_pkg::SUM_W'(r_p_yx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_xx   <= n_p_xx;
            r_p_yy   <= n_p_yy;
            r_p_xy   <= n_p_xy;
            r_p_yx   <= n_p_yx;
            r_zero_a <= n_zero;
            r_dot    <= n_dot;
            r_cross  <= n_cross;
            r_zero_b <= r_zero_a;
        end
    end

    assign o_valid = r_valid_b;
    assign o_dot   = r_dot;
    assign o_cross = r_cross;
    assign o_zero  = r_zero_b;

endmodule

[rtl/sabv_prerot.sv]
// ----------------------------------------------------------------------------
// Signed angle between vectors: pre-rotation
// Sorts out the special cases and loads the CORDIC start vector and angle.
// ----------------------------------------------------------------------------
module sabv_prerot (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [sabv_pkg::SUM_W-1:0]     i_dot,
    input  logic signed [sabv_pkg::SUM_W-1:0]     i_cross,
    input  logic                                  i_zero,
    output logic                                  o_valid,
    output sabv_pkg::t_cor                        o_cor
);

    logic signed [sabv_pkg::SUM_W-1:0] abs_cross;
    logic signed [sabv_pkg::XY_W-1:0]  dot_ext, abs_ext;
    logic                              cross_zero, dot_zero;
    sabv_pkg::t_cor                    n_cor, r_cor;
    logic                              r_valid;

    always_comb begin
        abs_cross  = i_cross[sabv_pkg::SUM_W-1] ? -i_cross : i_cross;
        dot_ext    = sabv_pkg::XY_W'(i_dot);
        abs_ext    = sabv_pkg::XY_W'(abs_cross);
        cross_zero = (i_cross == '0);
        dot_zero   = (i_dot == '0);

        n_cor.side.zero_vec = i_zero;
        n_cor.side.pos      = !i_cross[sabv_pkg::SUM_W-1] && !cross_zero;
        n_cor.side.fixed    = i_zero || cross_zero || dot_zero;
        if (cross_zero) begin
            n_cor.side.fixed_mag = (!i_dot[sabv_pkg::SUM_W-1] && !dot_zero) ?
                                   '0 : sabv_pkg::PI_Q13;
        end else begin
            n_cor.side.fixed_mag = sabv_pkg::HALF_PI_Q13;
        end

        // A vector in the left half plane is turned by -pi/2 first.
        if (i_dot[sabv_pkg::SUM_W-1]) begin
            n_cor.x = abs_ext;
            n_cor.y = -dot_ext;
            n_cor.z = sabv_pkg::HALF_PI_Q30;
        end else begin
            n_cor.x = dot_ext;
            n_cor.y = abs_ext;
            n_cor.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cor <= n_cor;
        end
    end

    assign o_valid = r_valid;
    assign o_cor   = r_cor;

endmodule

[rtl/sabv_cordic_stage.sv]
// ----------------------------------------------------------------------------
// Signed angle between vectors: CORDIC stage
// One registered vectoring iteration; the shift amount selects the table entry.
// ----------------------------------------------------------------------------
module sabv_cordic_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [sabv_pkg::IDX_W-1:0]     i_idx,
    input  logic                           i_valid,
    input  sabv_pkg::t_cor                 i_cor,
    output logic                           o_valid,
    output sabv_pkg::t_cor                 o_cor
);

    logic signed [sabv_pkg::XY_W-1:0] xs, ys;
    logic signed [sabv_pkg::Z_W-1:0]  step;
    sabv_pkg::t_cor                   n_cor, r_cor;
    logic                             r_valid;

    always_comb begin
        // Arithmetic shifts round toward minus infinity.
        xs   = i_cor.x >>> i_idx;
        ys   = i_cor.y >>> i_idx;
        step = $signed(sabv_pkg::atan_q30(i_idx));
        n_cor.side = i_cor.side;
        if (!i_cor.y[sabv_pkg::XY_W-1] && (i_cor.y != '0)) begin
            n_cor.x = i_cor.x + ys;
            n_cor.y = i_cor.y - xs;
            n_cor.z = i_cor.z + step;
        end else begin
            n_cor.x = i_cor.x - ys;
            n_cor.y = i_cor.y + xs;
            n_cor.z = i_cor.z - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cor <= n_cor;
        end
    end

    assign o_valid = r_valid;
    assign o_cor   = r_cor;

endmodule

[rtl/sabv_finish.sv]
// ----------------------------------------------------------------------------
// Signed angle between vectors: result stage
// Rounds the angle to Q3.13, clamps it, applies the sign and holds the result.
// ----------------------------------------------------------------------------
module sabv_finish (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sabv_pkg::t_cor  i_cor,
    output logic            o_valid,
    output sabv_pkg::t_out  o_data
);

    logic [sabv_pkg::Z_W-2:0]   z_pos;
    logic [sabv_pkg::Z_W-1:0]   z_sum;
    logic [sabv_pkg::RND_W-1:0] z_rnd;
    logic [sabv_pkg::MAG_W-1:0] mag_cordic, mag;
    logic [sabv_pkg::ANG_W-1:0] mag_ext;
    sabv_pkg::t_out             n_data, r_data;
    logic                       r_valid;

    always_comb begin
        z_pos   = i_cor.z[sabv_pkg::Z_W-1] ? '0 : i_cor.z[sabv_pkg::Z_W-2:0];
        z_sum   = {1'b0, z_pos} + sabv_pkg::Z_W'(65536);
        z_rnd   = z_sum[sabv_pkg::Z_W-1:17];
        mag_cordic = (z_rnd > sabv_pkg::RND_W'(sabv_pkg::PI_Q13)) ?
                     sabv_pkg::PI_Q13 : z_rnd[sabv_pkg::MAG_W-1:0];
        mag     = i_cor.side.fixed ? i_cor.side.fixed_mag : mag_cordic;
        mag_ext = sabv_pkg::ANG_W'(mag);

        n_data.zero_vector = i_cor.side.zero_vec;
        if (i_cor.side.zero_vec) begin
            n_data.angle = '0;
        end else if (i_cor.side.pos) begin
            n_data.angle = $signed(mag_ext);
        end else begin
            n_data.angle = -$signed(mag_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/signed_angle_between_vectors_top.sv]
// Stages from input acceptance to result: 2 product stages, 1 pre-rotation stage,
// 16 CORDIC iteration stages and 1 result stage; results are delayed while stalled.
// Throughput: one item per cycle if not stalled; each CORDIC iteration has its own stage.
// The whole pipeline holds only while a finished result waits under output stall.
// Reset (synchronous, active low) clears all stage valid bits; data needs no reset.
// ----------------------------------------------------------------------------
// Signed angle between vectors: top level
// atan2(cross, dot) of two 2D vectors through a pipelined CORDIC, Q3.13 radians.
// ----------------------------------------------------------------------------
module signed_angle_between_vectors_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  sabv_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output sabv_pkg::t_out  o_data
);

    logic                              en;
    logic                              prod_valid;
    logic signed [sabv_pkg::SUM_W-1:0] prod_dot, prod_cross;
    logic                              prod_zero;
    logic                              cor_valid [0:sabv_pkg::NUM_ITER];
    sabv_pkg::t_cor                    cor_data  [0:sabv_pkg::NUM_ITER];

    // The pipeline moves unless a result is waiting and the sink stalls.
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    sabv_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (prod_valid),
        .o_dot   (prod_dot),
        .o_cross (prod_cross),
        .o_zero  (prod_zero)
    );

    sabv_prerot u_prerot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prod_valid),
        .i_dot   (prod_dot),
        .i_cross (prod_cross),
        .i_zero  (prod_zero),
        .o_valid (cor_valid[0]),
        .o_cor   (cor_data[0])
    );

    for (genvar k = 0; k < sabv_pkg::NUM_ITER; k++) begin : g_iter
        sabv_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_idx   (sabv_pkg::IDX_W'(k)),
            .i_valid (cor_valid[k]),
            .i_cor   (cor_data[k]),
            .o_valid (cor_valid[k+1]),
            .o_cor   (cor_data[k+1])
        );
    end

    sabv_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cor_valid[sabv_pkg::NUM_ITER]),
        .i_cor   (cor_data[sabv_pkg::NUM_ITER]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

`ifndef SYNTHESIS
    a_zero_angle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.zero_vector) |-> (o_data.angle == '0))
        else $error("zero vector result with nonzero angle");

    a_angle_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.angle >= -16'sd25736) && (o_data.angle <= 16'sd25736)))
        else $error("angle outside minus pi to pi");

    a_stall_needs_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    a_hold_while_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cor_valid[0] && o_valid && i_stall) |=> cor_valid[0])
        else $error("pipeline item lost during output stall");
`endif

endmodule

[bench/signed_angle_between_vectors_top_tb.sv]
// ----------------------------------------------------------------------------
// Signed angle between vectors: testbench
// Sends vector pairs through the CORDIC angle block. A directed set covers
// the zero-vector, collinear, antiparallel and perpendicular cases and the
// component extremes, then random pairs follow. Random gaps on the input,
// random output stall and one long output hold are applied. A scoreboard
// predicts each angle and compares the results in order.
// ----------------------------------------------------------------------------
module signed_angle_between_vectors_top_tb;

    localparam int RANDOM_ITEMS     = 1850;
    localparam int LONG_HOLD_CYCLES = 160;
    localparam int LONG_HOLD_AFTER  = 600;
    localparam int DRAIN_CYCLES     = 40;
    localparam int TIMEOUT          = 3_000_000;

    localparam longint PI_MAG      = 25736;
    localparam longint HALF_PI_MAG = 12868;
    localparam longint HALF_PI_Z   = 1686629713;
    localparam int     ATAN_LEN    = 24;

    // atan(2^-i) scaled by 2^30, truncated.
    localparam longint ATAN_Q30 [ATAN_LEN] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6,
        'h03FEAB76, 'h01FFD55B, 'h00FFFAAA, 'h007FFF55,
        'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF,
        'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
        'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F
    };

    typedef logic signed [sabv_pkg::COMPONENT_BITS-1:0] t_comp;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } t_stall_mode;

    class angle_scoreboard;
        sabv_pkg::t_out expected_angles[$];
        int             mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Angle magnitude in Q3.13 for y > 0 and x != 0.
        function longint cordic_magnitude(longint x_in, longint y_in);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            x = x_in;
            y = y_in;
            z = 0;
            if (x < 0) begin
                x = y_in;
                y = -x_in;
                z = HALF_PI_Z;
            end
            for (int i = 0; i < sabv_pkg::CORDIC_STAGES && i < ATAN_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Q30[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Q30[i];
                end
            end
            if (z < 0)
                z = 0;
            z = (z + 65536) >>> 17;
            if (z > PI_MAG)
                z = PI_MAG;
            return z;
        endfunction

        function sabv_pkg::t_out predict_angle(sabv_pkg::t_in pair);
            sabv_pkg::t_out res;
            longint         ax;
            longint         ay;
            longint         bx;
            longint         by;
            longint         dot;
            longint         crs;
            longint         mag;
            longint         ang;
            ax = pair.a_x;
            ay = pair.a_y;
            bx = pair.b_x;
            by = pair.b_y;
            res.angle = '0;
            res.zero_vector = 1'b0;
            if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
                res.zero_vector = 1'b1;
                return res;
            end
            dot = ax * bx + ay * by;
            crs = ax * by - ay * bx;
            if (crs == 0)
                mag = (dot > 0) ? 0 : PI_MAG;
            else if (dot == 0)
                mag = HALF_PI_MAG;
            else
                mag = cordic_magnitude(dot, (crs < 0) ? -crs : crs);
            ang = (crs > 0) ? mag : -mag;
            res.angle = sabv_pkg::ANG_W'(ang);
            return res;
        endfunction

        function void note_pair(sabv_pkg::t_in pair);
            expected_angles.push_back(predict_angle(pair));
        endfunction

        function void check_angle(sabv_pkg::t_out got);
            sabv_pkg::t_out want;
            if (expected_angles.size() == 0) begin
                $error("unexpected result: angle %0d zero_vector %0b",
                       $signed(got.angle), got.zero_vector);
                mismatches++;
                return;
            end
            want = expected_angles.pop_front();
            if (got.angle !== want.angle) begin
                $error("angle: expected %0d, actual %0d",
                       $signed(want.angle), $signed(got.angle));
                mismatches++;
            end
            if (got.zero_vector !== want.zero_vector) begin
                $error("zero_vector: expected %0b, actual %0b",
                       want.zero_vector, got.zero_vector);
                mismatches++;
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    sabv_pkg::t_in  i_data;
    logic           o_valid;
    logic           i_stall;
    sabv_pkg::t_out o_data;

    angle_scoreboard sb = new();
    int items_sent = 0;

    signed_angle_between_vectors_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_comp pick(int lo, int hi);
        return t_comp'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    function automatic t_comp pick_extreme();
        case ($urandom_range(0, 5))
            0: return t_comp'(-32768);
            1: return t_comp'(-32767);
            2: return t_comp'(-1);
            3: return t_comp'(0);
            4: return t_comp'(1);
            default: return t_comp'(32767);
        endcase
    endfunction

    function automatic sabv_pkg::t_in make_pair(int ax, int ay, int bx, int by);
        sabv_pkg::t_in p;
        p.a_x = t_comp'(ax);
        p.a_y = t_comp'(ay);
        p.b_x = t_comp'(bx);
        p.b_y = t_comp'(by);
        return p;
    endfunction

    function automatic sabv_pkg::t_in random_pair();
        sabv_pkg::t_in p;
        int            k;
        p.a_x = t_comp'($urandom);
        p.a_y = t_comp'($urandom);
        p.b_x = t_comp'($urandom);
        p.b_y = t_comp'($urandom);
        case ($urandom_range(0, 9))
            3: begin
                p.a_x = pick(-8, 8);
                p.a_y = pick(-8, 8);
                p.b_x = pick(-8, 8);
                p.b_y = pick(-8, 8);
            end
            4: begin
                // Collinear, either direction; a zero factor gives a zero vector.
                p.a_x = pick(-100, 100);
                p.a_y = pick(-100, 100);
                k = int'(pick(-300, 300));
                p.b_x = t_comp'(k * int'(p.a_x));
                p.b_y = t_comp'(k * int'(p.a_y));
            end
            5: begin
                p.a_x = pick(-150, 150);
                p.a_y = pick(-150, 150);
                k = int'(pick(-200, 200));
                p.b_x = t_comp'(-k * int'(p.a_y));
                p.b_y = t_comp'(k * int'(p.a_x));
            end
            6: begin
                if ($urandom_range(0, 1) == 0) begin
                    p.a_x = '0;
                    p.a_y = '0;
                end else begin
                    p.b_x = '0;
                    p.b_y = '0;
                end
            end
            7: begin
                p.a_x = pick_extreme();
                p.a_y = pick_extreme();
                p.b_x = pick_extreme();
                p.b_y = pick_extreme();
            end
            8, 9: begin
                p.a_x = pick(-1000, 1000);
                p.a_y = pick(-1000, 1000);
                p.b_x = pick(-1000, 1000);
                p.b_y = pick(-1000, 1000);
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(input sabv_pkg::t_in pair);
        i_valid <= 1'b1;
        i_data  <= pair;
        do
            @(posedge i_clk);
        while (o_stall);
        sb.note_pair(pair);
        items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Random bursts with random gaps between them.
    task automatic send_random_pairs(input int count);
        int burst;
        int done;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && done < count; j++) begin
                send_pair(random_pair());
                done++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_angle(o_data);
    end

    // Output stall: segments of different density, plus one long hold once
    // the input side has moved far enough to keep offering items.
    initial begin
        t_stall_mode mode;
        int          seg_len;
        bit          long_hold_done;
        bit          toggle;
        long_hold_done = 1'b0;
        toggle = 1'b0;
        forever begin
            if (!long_hold_done && items_sent >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = t_stall_mode'($urandom_range(0, 3));
                seg_len = $urandom_range(5, 60);
                repeat (seg_len) begin
                    case (mode)
                        STALL_NONE:  i_stall <= 1'b0;
                        STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                        STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
                        default: begin
                            toggle = ~toggle;
                            i_stall <= toggle;
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero vectors.
        send_pair(make_pair(0, 0, 5, 7));
        send_pair(make_pair(3, -4, 0, 0));
        send_pair(make_pair(0, 0, 0, 0));
        // Collinear and antiparallel.
        send_pair(make_pair(100, 0, 200, 0));
        send_pair(make_pair(100, 0, -50, 0));
        send_pair(make_pair(3, 4, -6, -8));
        // Perpendicular, both senses.
        send_pair(make_pair(1, 0, 0, 1));
        send_pair(make_pair(1, 0, 0, -1));
        idle_cycles(3);
        // Negative dot product with both signs of the cross product, and a small positive angle.
        send_pair(make_pair(1000, 100, -900, 300));
        send_pair(make_pair(1000, 100, -900, -300));
        send_pair(make_pair(1000, 0, 1000, 1));
        send_pair(make_pair(1000, 0, -1000, 1));
        send_pair(make_pair(1000, 0, -1000, -1));
        // Component extremes.
        send_pair(make_pair(-32768, -32768, -32768, -32768));
        send_pair(make_pair(32767, 32767, -32768, -32768));
        send_pair(make_pair(-32768, 32767, 32767, -32768));
        send_pair(make_pair(32767, -32768, 32767, 32767));
        send_pair(make_pair(-32768, 0, 0, -32768));
        send_pair(make_pair(0, 32767, -32768, 0));
        send_pair(make_pair(-1, -1, 1, -1));
        send_pair(make_pair(32767, 0, -32768, 1));
        send_pair(make_pair(-32768, -1, 32767, 32767));
        idle_cycles(2);

        send_random_pairs(RANDOM_ITEMS);
        i_valid <= 1'b0;

        while (sb.expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[signed_angle_between_vectors_top.f]
rtl/sabv_pkg.sv
rtl/sabv_products.sv
rtl/sabv_prerot.sv
rtl/sabv_cordic_stage.sv
rtl/sabv_finish.sv
rtl/signed_angle_between_vectors_top.sv
bench/signed_angle_between_vectors_top_tb.sv
